// ===== hw/rtl/las_pkg.sv =====
package las_pkg;

    localparam int CELL_W    = 8;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [CFG_W-1:0]  cfg_val_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

    localparam cfg_val_t MATCH_RESET    = 4'd2;
    localparam cfg_val_t MISMATCH_RESET = 4'd1;
    localparam cfg_val_t GAP_RESET      = 4'd1;

    function automatic cell_t sat_add(input cell_t a, input cfg_val_t b);
        logic [CELL_W:0] s;
        s = {1'b0, a} + {{(CELL_W + 1 - CFG_W){1'b0}}, b};
        return s[CELL_W] ? {CELL_W{1'b1}} : s[CELL_W-1:0];
    endfunction

    function automatic cell_t sat_sub(input cell_t a, input cfg_val_t b);
        cell_t bw;
        bw = {{(CELL_W - CFG_W){1'b0}}, b};
        return (a > bw) ? (a - bw) : '0;
    endfunction

    function automatic cell_t max_cell(input cell_t a, input cell_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== hw/rtl/las_ram.sv =====
module las_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/local_alignment_score.sv =====
// Reference load items are accepted in S_IDLE, and loads can follow every cycle there.
// A query item on a non-empty reference stalls the input through S_RUN and S_DRAIN while
// the row memory is walked one cell per cycle. A query item marked last then passes
// S_FINISH, where best_score is registered and out_valid raised once any earlier result is
// taken; with an empty reference it goes straight there. Reset restores the default scores,
// empties the reference, clears the row valid bits at once; the memories need no clearing pass.
module local_alignment_score #(
    parameter int REF_LEN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [7:0]                    symbol,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    best_score,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [las_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [las_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW = (REF_LEN > 1) ? $clog2(REF_LEN) : 1;
    localparam int LW = $clog2(REF_LEN + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]              state_reg, state_next;
    las_pkg::cfg_val_t       match_reg, match_next;
    las_pkg::cfg_val_t       mism_reg, mism_next;
    las_pkg::cfg_val_t       gap_reg, gap_next;
    logic [LW-1:0]           ref_len_reg, ref_len_next;
    logic                    done_reg, done_next;
    las_pkg::cell_t          best_reg, best_next;
    logic [REF_LEN-1:0]      row_valid_reg, row_valid_next;
    logic [AW-1:0]           rd_addr_reg, rd_addr_next;
    logic                    pv_reg, pv_next;
    logic                    out_valid_reg, out_valid_next;

    las_pkg::cell_t          sym_reg, sym_next;
    logic                    last_reg, last_next;
    logic [AW-1:0]           pj_reg, pj_next;
    logic                    pup_valid_reg, pup_valid_next;
    las_pkg::cell_t          diag_reg, diag_next;
    las_pkg::cell_t          left_reg, left_next;
    las_pkg::cell_t          best_score_reg, best_score_next;

    logic                    in_accept;
    logic                    load_acc;
    logic                    query_acc;
    logic [LW-1:0]           len_base;
    logic                    ref_we;
    logic                    rd_issue;
    logic                    last_addr;
    logic                    fin_fire;
    logic                    clear_q;
    logic                    row_we;
    las_pkg::cell_t          ref_rdata;
    las_pkg::cell_t          row_rdata;
    las_pkg::cell_t          up_val;
    las_pkg::cell_t          diag_term;
    las_pkg::cell_t          h_val;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign load_acc  = in_accept && (operation == las_pkg::OP_LOAD);
    assign query_acc = in_accept && (operation == las_pkg::OP_QUERY);
    assign len_base  = done_reg ? '0 : ref_len_reg;
    assign ref_we    = load_acc && (len_base < LW'(REF_LEN));
    assign rd_issue  = (state_reg == S_RUN);
    assign last_addr = (LW'(rd_addr_reg) == (ref_len_reg - LW'(1)));
    assign fin_fire  = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);
    assign clear_q   = load_acc || fin_fire;
    assign row_we    = pv_reg;

    las_ram #(
        .WIDTH (las_pkg::CELL_W),
        .DEPTH (REF_LEN)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (len_base[AW-1:0]),
        .wdata (symbol),
        .re    (rd_issue),
        .raddr (rd_addr_reg),
        .rdata (ref_rdata)
    );

    las_ram #(
        .WIDTH (las_pkg::CELL_W),
        .DEPTH (REF_LEN)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (pj_reg),
        .wdata (h_val),
        .re    (rd_issue),
        .raddr (rd_addr_reg),
        .rdata (row_rdata)
    );

    // A row entry that has not been written since the last clear reads as zero.
    always_comb
    begin
        up_val    = pup_valid_reg ? row_rdata : '0;
        diag_term = (ref_rdata == sym_reg) ? las_pkg::sat_add(diag_reg, match_reg)
                                           : las_pkg::sat_sub(diag_reg, mism_reg);
        h_val     = las_pkg::max_cell(diag_term,
                        las_pkg::max_cell(las_pkg::sat_sub(up_val, gap_reg),
                                          las_pkg::sat_sub(left_reg, gap_reg)));
    end

    always_comb
    begin
        state_next      = state_reg;
        match_next      = match_reg;
        mism_next       = mism_reg;
        gap_next        = gap_reg;
        ref_len_next    = ref_len_reg;
        done_next       = done_reg;
        best_next       = best_reg;
        row_valid_next  = row_valid_reg;
        rd_addr_next    = rd_addr_reg;
        pv_next         = rd_issue;
        out_valid_next  = out_valid_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        pj_next         = rd_addr_reg;
        pup_valid_next  = row_valid_reg[rd_addr_reg];
        diag_next       = diag_reg;
        left_next       = left_reg;
        best_score_next = best_score_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                las_pkg::CFG_MATCH:    match_next = cfg_data;
                las_pkg::CFG_MISMATCH: mism_next  = cfg_data;
                las_pkg::CFG_GAP:      gap_next   = cfg_data;
                default:               ;
            endcase
        end

        if (load_acc)
        begin
            ref_len_next = ref_we ? (len_base + LW'(1)) : len_base;
            done_next    = last;
        end

        if (query_acc)
        begin
            done_next    = 1'b1;
            sym_next     = symbol;
            last_next    = last;
            rd_addr_next = '0;
            diag_next    = '0;
            left_next    = '0;
        end

        if (rd_issue)
        begin
            rd_addr_next = rd_addr_reg + AW'(1);
        end

        if (row_we)
        begin
            diag_next = up_val;
            left_next = h_val;
            best_next = las_pkg::max_cell(best_reg, h_val);
            row_valid_next[pj_reg] = 1'b1;
        end

        if (clear_q)
        begin
            row_valid_next = '0;
            best_next      = '0;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (fin_fire)
        begin
            out_valid_next  = 1'b1;
            best_score_next = best_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (query_acc)
                begin
                    if (ref_len_reg == '0)
                    begin
                        state_next = last ? S_FINISH : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                if (last_addr)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = last_reg ? S_FINISH : S_IDLE;
            end
            S_FINISH:
            begin
                if (fin_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            match_reg     <= las_pkg::MATCH_RESET;
            mism_reg      <= las_pkg::MISMATCH_RESET;
            gap_reg       <= las_pkg::GAP_RESET;
            ref_len_reg   <= '0;
            done_reg      <= 1'b0;
            best_reg      <= '0;
            row_valid_reg <= '0;
            rd_addr_reg   <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            match_reg     <= match_next;
            mism_reg      <= mism_next;
            gap_reg       <= gap_next;
            ref_len_reg   <= ref_len_next;
            done_reg      <= done_next;
            best_reg      <= best_next;
            row_valid_reg <= row_valid_next;
            rd_addr_reg   <= rd_addr_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        last_reg       <= last_next;
        pj_reg         <= pj_next;
        pup_valid_reg  <= pup_valid_next;
        diag_reg       <= diag_next;
        left_reg       <= left_next;
        best_score_reg <= best_score_next;
    end

    assign out_valid  = out_valid_reg;
    assign best_score = best_score_reg;
    assign cfg_ready  = 1'b1;

    a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> pv_reg)
        else $error("drain cycle without a pending cell");

    a_row_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> (LW'(pj_reg) < ref_len_reg))
        else $error("row write beyond the reference length");

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (ref_len_reg != '0))
        else $error("row walk with an empty reference");

    a_read_then_cell: assert property (@(posedge clk) disable iff (!rst_n)
        rd_issue |=> (pv_reg && (state_reg == S_RUN || state_reg == S_DRAIN)))
        else $error("memory read not followed by a cell update");

    a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fire |=> (out_valid_reg && (best_reg == '0) && (row_valid_reg == '0)))
        else $error("result not shown or query state not cleared");

endmodule

// ===== sim/local_alignment_score_test.sv =====
module local_alignment_score_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REF_LEN = 64;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_ITEMS = 160;
    localparam int SETTLE_CYCLES = REF_LEN + 16;
    localparam int QUIET_LIMIT = 4000;
    localparam las_pkg::cfg_val_t SCORE_MAX = 4'hF;
    localparam las_pkg::cfg_val_t SCORE_MIN = 4'h0;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          operation = las_pkg::OP_LOAD;
    logic [7:0]                    symbol = '0;
    logic                          last = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [7:0]                    best_score;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [las_pkg::CFG_IDX_W-1:0] cfg_index = las_pkg::CFG_MATCH;
    logic [las_pkg::CFG_W-1:0]     cfg_data = '0;

    las_pkg::cell_t    ref_syms[REF_LEN] = '{default: '0};
    las_pkg::cell_t    row_scores[REF_LEN] = '{default: '0};
    int                ref_count = 0;
    las_pkg::cell_t    best_so_far = '0;
    bit                ref_closed = 1'b0;
    las_pkg::cfg_val_t match_add = las_pkg::MATCH_RESET;
    las_pkg::cfg_val_t mismatch_sub = las_pkg::MISMATCH_RESET;
    las_pkg::cfg_val_t gap_sub = las_pkg::GAP_RESET;

    las_pkg::cell_t expected_scores[$];
    las_pkg::cell_t wanted_score;

    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int saturated_results = 0;
    int settings_used = 0;
    int burst_left = 0;
    bit gaps_enabled = 1'b1;
    int alpha_size = 0;
    las_pkg::cell_t alpha_base = '0;
    int stall_mode = 0;
    int mode_left = 0;
    int stall_tick = 0;
    int quiet_cycles = 0;

    always #1 clk = ~clk;

    local_alignment_score #(
        .REF_LEN(REF_LEN)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .symbol(symbol),
        .last(last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .best_score(best_score),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic las_pkg::cell_t add_clamp(las_pkg::cell_t a, las_pkg::cfg_val_t b);
        int s;
        s = int'(a) + int'(b);
        return (s > 255) ? 8'hFF : las_pkg::cell_t'(s);
    endfunction

    function automatic las_pkg::cell_t sub_clamp(las_pkg::cell_t a, las_pkg::cfg_val_t b);
        return (a > las_pkg::cell_t'(b)) ? a - las_pkg::cell_t'(b) : '0;
    endfunction

    function automatic las_pkg::cell_t larger(las_pkg::cell_t a, las_pkg::cell_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic las_pkg::cell_t pick_symbol();
        if (alpha_size == 0)
        begin
            return las_pkg::cell_t'($urandom);
        end
        return alpha_base + las_pkg::cell_t'($urandom_range(0, alpha_size - 1));
    endfunction

    task automatic clear_query_state();
        for (int j = 0; j < REF_LEN; j++)
        begin
            row_scores[j] = '0;
        end
        best_so_far = '0;
    endtask

    task automatic score_row(logic op, las_pkg::cell_t sym, logic lst);
        las_pkg::cell_t diag;
        las_pkg::cell_t left;
        las_pkg::cell_t up;
        las_pkg::cell_t h;
        if (op == las_pkg::OP_LOAD)
        begin
            if (ref_closed)
            begin
                ref_count = 0;
                ref_closed = 1'b0;
            end
            clear_query_state();
            if (ref_count < REF_LEN)
            begin
                ref_syms[ref_count] = sym;
                ref_count++;
            end
            if (lst)
            begin
                ref_closed = 1'b1;
            end
        end
        else
        begin
            ref_closed = 1'b1;
            diag = '0;
            left = '0;
            for (int j = 0; j < ref_count; j++)
            begin
                up = row_scores[j];
                h = (ref_syms[j] == sym) ? add_clamp(diag, match_add)
                                         : sub_clamp(diag, mismatch_sub);
                h = larger(h, sub_clamp(up, gap_sub));
                h = larger(h, sub_clamp(left, gap_sub));
                diag = up;
                left = h;
                row_scores[j] = h;
                best_so_far = larger(best_so_far, h);
            end
            if (lst)
            begin
                expected_scores.push_back(best_so_far);
                if (best_so_far == 8'hFF)
                begin
                    saturated_results++;
                end
                clear_query_state();
            end
        end
    endtask

    task automatic send_item(logic op, las_pkg::cell_t sym, logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 2);
            if (gaps_enabled && gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        operation <= op;
        symbol <= sym;
        last <= lst;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        score_row(op, sym, lst);
        items_sent++;
    endtask

    task automatic send_run(logic op, int count, logic close);
        for (int i = 0; i < count; i++)
        begin
            send_item(op, pick_symbol(), close && (i == count - 1));
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_scores.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [las_pkg::CFG_IDX_W-1:0] idx, las_pkg::cfg_val_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            las_pkg::CFG_MATCH:    match_add = value;
            las_pkg::CFG_MISMATCH: mismatch_sub = value;
            las_pkg::CFG_GAP:      gap_sub = value;
            default:               ;
        endcase
    endtask

    task automatic set_scores(las_pkg::cfg_val_t m, las_pkg::cfg_val_t mm,
                              las_pkg::cfg_val_t g);
        write_reg(las_pkg::CFG_MATCH, m);
        write_reg(las_pkg::CFG_MISMATCH, mm);
        write_reg(las_pkg::CFG_GAP, g);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic test_empty_reference();
        send_item(las_pkg::OP_QUERY, 8'h00, 1'b1);
    endtask

    task automatic test_basic_alignment();
        send_item(las_pkg::OP_LOAD, 8'h00, 1'b0);
        send_item(las_pkg::OP_LOAD, 8'hFF, 1'b0);
        send_item(las_pkg::OP_LOAD, 8'hA5, 1'b1);
        send_item(las_pkg::OP_QUERY, 8'hFF, 1'b0);
        send_item(las_pkg::OP_QUERY, 8'hA5, 1'b1);
        send_item(las_pkg::OP_QUERY, 8'h5A, 1'b1);
    endtask

    task automatic test_new_reference_after_complete();
        send_item(las_pkg::OP_LOAD, 8'h3C, 1'b0);
        send_item(las_pkg::OP_LOAD, 8'hC3, 1'b1);
        send_item(las_pkg::OP_QUERY, 8'hC3, 1'b1);
    endtask

    task automatic test_load_during_query();
        send_item(las_pkg::OP_QUERY, 8'h3C, 1'b0);
        send_item(las_pkg::OP_LOAD, 8'h3C, 1'b0);
        send_item(las_pkg::OP_LOAD, 8'h3C, 1'b1);
        send_item(las_pkg::OP_QUERY, 8'h3C, 1'b1);
    endtask

    task automatic test_query_before_reference_complete();
        send_item(las_pkg::OP_LOAD, 8'h11, 1'b0);
        send_item(las_pkg::OP_LOAD, 8'h22, 1'b0);
        send_item(las_pkg::OP_QUERY, 8'h22, 1'b1);
        send_item(las_pkg::OP_LOAD, 8'h11, 1'b1);
        send_item(las_pkg::OP_QUERY, 8'h11, 1'b1);
    endtask

    task automatic test_score_extremes();
        drain_results();
        set_scores(SCORE_MAX, SCORE_MAX, SCORE_MAX);
        send_item(las_pkg::OP_LOAD, 8'h80, 1'b0);
        send_item(las_pkg::OP_LOAD, 8'h80, 1'b1);
        send_item(las_pkg::OP_QUERY, 8'h80, 1'b0);
        send_item(las_pkg::OP_QUERY, 8'h80, 1'b1);
        drain_results();
        set_scores(SCORE_MIN, SCORE_MIN, SCORE_MIN);
        send_item(las_pkg::OP_QUERY, 8'h7F, 1'b0);
        send_item(las_pkg::OP_QUERY, 8'h80, 1'b1);
    endtask

    task automatic test_random_traffic();
        int phase;
        int start;
        int phase_start;
        int kind;
        int max_len;
        int ref_len_now;
        phase = 0;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            drain_results();
            case (phase % 7)
                0: set_scores(las_pkg::MATCH_RESET, las_pkg::MISMATCH_RESET,
                              las_pkg::GAP_RESET);
                1: set_scores(SCORE_MIN, SCORE_MIN, SCORE_MIN);
                2: set_scores(SCORE_MAX, SCORE_MAX, SCORE_MAX);
                3: set_scores(SCORE_MAX, SCORE_MIN, SCORE_MIN);
                4: set_scores(SCORE_MIN, SCORE_MAX, SCORE_MAX);
                5: set_scores(SCORE_MAX, SCORE_MAX, SCORE_MIN);
                default: set_scores(las_pkg::cfg_val_t'($urandom_range(0, 15)),
                                    las_pkg::cfg_val_t'($urandom_range(0, 15)),
                                    las_pkg::cfg_val_t'($urandom_range(0, 15)));
            endcase
            case ($urandom_range(0, 3))
                0: alpha_size = 0;
                1: alpha_size = 1;
                2: alpha_size = 2;
                default: alpha_size = 4;
            endcase
            alpha_base = las_pkg::cell_t'($urandom);
            max_len = (alpha_size == 1) ? 40 : 12;
            gaps_enabled = (phase % 3 != 1);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                kind = $urandom_range(0, 9);
                ref_len_now = ($urandom_range(0, 9) == 0)
                    ? $urandom_range(REF_LEN - 2, REF_LEN + 4) : $urandom_range(1, max_len);
                if (kind <= 6)
                begin
                    send_run(las_pkg::OP_LOAD, ref_len_now, 1'b1);
                    repeat ($urandom_range(1, 4))
                    begin
                        send_run(las_pkg::OP_QUERY, $urandom_range(1, max_len), 1'b1);
                    end
                end
                else if (kind == 7)
                begin
                    send_run(las_pkg::OP_LOAD, ref_len_now, 1'b1);
                    send_run(las_pkg::OP_QUERY, $urandom_range(1, max_len), 1'b0);
                end
                else if (kind == 8)
                begin
                    send_run(las_pkg::OP_LOAD, ref_len_now, 1'b0);
                    send_run(las_pkg::OP_QUERY, $urandom_range(1, max_len), 1'b1);
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        send_item(1'($urandom_range(0, 1)), las_pkg::cell_t'($urandom),
                                  1'($urandom_range(0, 1)));
                    end
                end
            end
            phase++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_scores.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected best_score, expected none, actual %0d",
                         $time, best_score);
            end
            else
            begin
                wanted_score = expected_scores.pop_front();
                results_checked++;
                if (best_score !== wanted_score)
                begin
                    errors++;
                    $display("%0t: best_score mismatch, expected %0d, actual %0d",
                             $time, wanted_score, best_score);
                end
            end
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 4);
            mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        stall_tick++;
        case (stall_mode)
            1: out_stall <= ($urandom_range(0, 7) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            3: out_stall <= ($urandom_range(0, 7) != 0);
            4: out_stall <= (stall_tick % 5 < 2);
            default: out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_reference();
        test_basic_alignment();
        test_new_reference_after_complete();
        test_load_during_query();
        test_query_before_reference_complete();
        test_score_extremes();
        test_random_traffic();
        drain_results();
        $display("Sent %0d items under %0d score settings; checked %0d best_score results.",
                 items_sent, settings_used, results_checked);
        $display("%0d results saturated at 255; %0d mismatches.", saturated_results, errors);
        if (errors == 0 && expected_scores.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
